### rtl/plist_pkg.sv
package plist_pkg;

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_BACK  = 3'd1;
	localparam logic [2:0] CMD_INS_AT    = 3'd2;
	localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [2:0] CMD_DEL_AT    = 3'd5;
	localparam logic [2:0] CMD_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] item_value;
		logic [4:0]         item_position;
		logic               last;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic [5:0] idx;
	} cell_ctrl_t;

endpackage

### rtl/plist_cell.sv
module plist_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  plist_pkg::cell_ctrl_t        ctrl,
	input  logic signed [DATA_WIDTH-1:0] new_value,
	input  logic signed [DATA_WIDTH-1:0] prev_value,
	input  logic signed [DATA_WIDTH-1:0] next_value,
	input  logic signed [DATA_WIDTH-1:0] head_value,
	output logic signed [DATA_WIDTH-1:0] value
);

	localparam logic [5:0] MY_IDX = 6'(INDEX);

	logic signed [DATA_WIDTH-1:0] value_q;
	logic signed [DATA_WIDTH-1:0] value_nx;

	always_comb begin
		value_nx = value_q;
		unique case (ctrl.op)
			plist_pkg::OP_HOLD: begin
				value_nx = value_q;
			end
			plist_pkg::OP_INSERT: begin
				if (MY_IDX == ctrl.idx) begin
					value_nx = new_value;
				end else if (MY_IDX > ctrl.idx) begin
					value_nx = prev_value;
				end
			end
			plist_pkg::OP_DELETE: begin
				if (MY_IDX >= ctrl.idx) begin
					value_nx = next_value;
				end
			end
			plist_pkg::OP_ROTATE: begin
				if (MY_IDX == ctrl.idx) begin
					value_nx = head_value;
				end else if (MY_IDX < ctrl.idx) begin
					value_nx = next_value;
				end
			end
			default: begin
				value_nx = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_nx;
	end

	assign value = value_q;

endmodule

### rtl/positional_list_engine.sv
// Ordered list of signed values held in a chain of cells, one element per
// cell with the front of the list in the first cell. Inserts and deletes
// shift the cells behind the chosen position by one as the request is
// taken, so every update request answers with one response. A dump of a
// non-empty list rotates the chain toward the first cell, which is read
// out each cycle that the output register is free, so it gives one
// response per stored element and leaves the list as it was; no request
// is taken while it runs. A new request is taken only when the output
// register is empty or its waiting response is taken in the same cycle,
// so a stalled response holds off the request side.
module positional_list_engine #(
	parameter int CAPACITY = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  plist_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output plist_pkg::rsp_t   rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t          state_q;
	logic            rsp_valid_q;
	plist_pkg::rsp_t rsp_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   dump_q;

	logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
	logic signed [DATA_WIDTH-1:0] new_value;

	plist_pkg::cell_ctrl_t ctrl;
	logic          out_free;
	logic          req_fire;
	logic          full;
	logic          empty;
	logic [8:0]    pos9;
	logic [8:0]    count9;
	logic [IW-1:0] pos_idx;
	logic [IW-1:0] tail_idx;
	logic [1:0]    status;
	logic [CW-1:0] count_nx;
	logic          dump_last;
	logic [CW-1:0] dump_pos;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign req_fire  = req_valid && req_ready;
	assign full      = count_q == CW'(CAPACITY);
	assign empty     = count_q == '0;
	assign pos9      = {1'b0, req.position};
	assign count9    = 9'(count_q);
	assign pos_idx   = IW'(req.position - 8'd1);
	assign tail_idx  = IW'(count_q - CW'(1));
	assign new_value = DATA_WIDTH'(req.value);
	assign dump_last = dump_q == tail_idx;
	assign dump_pos  = CW'(dump_q) + CW'(1);

	always_comb begin
		ctrl.op  = plist_pkg::OP_HOLD;
		ctrl.idx = '0;
		status   = plist_pkg::ST_OK;
		count_nx = count_q;
		if (req_fire) begin
			unique case (req.cmd)
				plist_pkg::CMD_INS_FRONT, plist_pkg::CMD_INS_BACK: begin
					if (full) begin
						status = plist_pkg::ST_FULL;
					end else begin
						ctrl.op  = plist_pkg::OP_INSERT;
						ctrl.idx = (req.cmd == plist_pkg::CMD_INS_FRONT) ? '0
							: 6'(IW'(count_q));
						count_nx = count_q + CW'(1);
					end
				end
				plist_pkg::CMD_INS_AT: begin
					if (pos9 == '0 || pos9 > count9 + 9'd1) begin
						status = plist_pkg::ST_BADPOS;
					end else if (full) begin
						status = plist_pkg::ST_FULL;
					end else begin
						ctrl.op  = plist_pkg::OP_INSERT;
						ctrl.idx = 6'(pos_idx);
						count_nx = count_q + CW'(1);
					end
				end
				plist_pkg::CMD_DEL_FRONT, plist_pkg::CMD_DEL_BACK: begin
					if (empty) begin
						status = plist_pkg::ST_EMPTY;
					end else begin
						ctrl.op  = plist_pkg::OP_DELETE;
						ctrl.idx = (req.cmd == plist_pkg::CMD_DEL_FRONT) ? '0
							: 6'(tail_idx);
						count_nx = count_q - CW'(1);
					end
				end
				plist_pkg::CMD_DEL_AT: begin
					if (empty) begin
						status = plist_pkg::ST_EMPTY;
					end else if (pos9 == '0 || pos9 > count9) begin
						status = plist_pkg::ST_BADPOS;
					end else begin
						ctrl.op  = plist_pkg::OP_DELETE;
						ctrl.idx = 6'(pos_idx);
						count_nx = count_q - CW'(1);
					end
				end
				plist_pkg::CMD_DUMP: begin
					status = empty ? plist_pkg::ST_EMPTY : plist_pkg::ST_OK;
				end
				default: begin
					status = plist_pkg::ST_OK;
				end
			endcase
		end else if (state_q == S_DUMP && out_free) begin
			ctrl.op  = plist_pkg::OP_ROTATE;
			ctrl.idx = 6'(tail_idx);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plist_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.new_value(new_value),
			.prev_value(cell_value[(i > 0) ? i - 1 : 0]),
			.next_value(cell_value[(i < CAPACITY - 1) ? i + 1 : i]),
			.head_value(cell_value[0]),
			.value(cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			count_q     <= '0;
			dump_q      <= '0;
		end else begin
			count_q <= count_nx;
			if (out_free) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.cmd == plist_pkg::CMD_DUMP && !empty) begin
							state_q <= S_DUMP;
							dump_q  <= '0;
						end else begin
							rsp_valid_q         <= 1'b1;
							rsp_q.status        <= status;
							rsp_q.count         <= 5'(count_nx);
							rsp_q.item_value    <= '0;
							rsp_q.item_position <= '0;
							rsp_q.last          <= 1'b1;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.status        <= plist_pkg::ST_OK;
						rsp_q.count         <= 5'(count_q);
						rsp_q.item_value    <= 32'(cell_value[0]);
						rsp_q.item_position <= 5'(dump_pos);
						rsp_q.last          <= dump_last;
						if (dump_last) begin
							state_q <= S_IDLE;
							dump_q  <= '0;
						end else begin
							dump_q <= dump_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("Element count exceeds capacity.");

	a_dump_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> (!empty && CW'(dump_q) < count_q))
		else $error("Dump index runs past the stored elements.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
			|| count_q == $past(count_q) - CW'(1)))
		else $error("Element count changed by more than one.");

endmodule

### bench/tb_positional_list_engine.sv
module tb_positional_list_engine;

	localparam int CAPACITY = 16;
	localparam logic [2:0] CMD_NOP = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	plist_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	plist_pkg::rsp_t rsp;

	logic signed [31:0] list_model[$];
	plist_pkg::rsp_t expected_rsp[$];
	plist_pkg::rsp_t want;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int n_requests = 0;
	int n_responses = 0;
	int n_dumps = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	positional_list_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic plist_pkg::rsp_t make_rsp(logic [1:0] status, logic [4:0] count,
			logic signed [31:0] item_value, logic [4:0] item_position, logic last);
		plist_pkg::rsp_t r;
		r.status = status;
		r.count = count;
		r.item_value = item_value;
		r.item_position = item_position;
		r.last = last;
		return r;
	endfunction

	function automatic plist_pkg::req_t make_req(logic [2:0] cmd, logic signed [31:0] value,
			logic [7:0] position);
		plist_pkg::req_t r;
		r.cmd = cmd;
		r.value = value;
		r.position = position;
		return r;
	endfunction

	function automatic void predict_list_update(plist_pkg::req_t r);
		logic [1:0] status;
		int size;
		status = plist_pkg::ST_OK;
		size = list_model.size();
		case (r.cmd)
			plist_pkg::CMD_INS_FRONT, plist_pkg::CMD_INS_BACK: begin
				if (size >= CAPACITY)
					status = plist_pkg::ST_FULL;
				else if (r.cmd == plist_pkg::CMD_INS_FRONT)
					list_model.push_front(r.value);
				else
					list_model.push_back(r.value);
			end
			plist_pkg::CMD_INS_AT: begin
				if (r.position == 0 || r.position > size + 1)
					status = plist_pkg::ST_BADPOS;
				else if (size >= CAPACITY)
					status = plist_pkg::ST_FULL;
				else
					list_model.insert(r.position - 1, r.value);
			end
			plist_pkg::CMD_DEL_FRONT, plist_pkg::CMD_DEL_BACK: begin
				if (size == 0)
					status = plist_pkg::ST_EMPTY;
				else if (r.cmd == plist_pkg::CMD_DEL_FRONT)
					void'(list_model.pop_front());
				else
					void'(list_model.pop_back());
			end
			plist_pkg::CMD_DEL_AT: begin
				if (size == 0)
					status = plist_pkg::ST_EMPTY;
				else if (r.position == 0 || r.position > size)
					status = plist_pkg::ST_BADPOS;
				else
					list_model.delete(r.position - 1);
			end
			plist_pkg::CMD_DUMP: begin
				if (size == 0) begin
					status = plist_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < size; i++)
						expected_rsp.push_back(make_rsp(plist_pkg::ST_OK, size[4:0],
							list_model[i], 5'(i + 1), i == size - 1));
					return;
				end
			end
			default: begin
			end
		endcase
		expected_rsp.push_back(make_rsp(status, 5'(list_model.size()), '0, '0, 1'b1));
	endfunction

	task automatic send_request(input plist_pkg::req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		predict_list_update(r);
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		n_requests++;
		if (r.cmd == plist_pkg::CMD_DUMP)
			n_dumps++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			n_responses++;
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
				errors++;
			end else begin
				want = expected_rsp.pop_front();
				compare_field("status", want.status, rsp.status);
				compare_field("count", want.count, rsp.count);
				compare_field("item_value", want.item_value, rsp.item_value);
				compare_field("item_position", want.item_position, rsp.item_position);
				compare_field("last", want.last, rsp.last);
				if (!$isunknown(rsp.status))
					status_seen[rsp.status]++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d responses outstanding",
					$time, quiet_cycles, expected_rsp.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic test_empty_list();
		send_request(make_req(plist_pkg::CMD_DUMP, 32'sd0, 8'd0));
		send_request(make_req(plist_pkg::CMD_DEL_BACK, 32'sd0, 8'd0));
		send_request(make_req(plist_pkg::CMD_DEL_AT, 32'sd0, 8'd1));
		send_request(make_req(plist_pkg::CMD_INS_AT, 32'sd5, 8'd2));
	endtask

	task automatic test_fill_to_capacity();
		logic signed [31:0] extremes[6];
		int size;
		extremes = '{32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sd1, 32'sh55555555,
			32'shaaaaaaaa};
		for (int i = 0; i < CAPACITY; i++) begin
			size = list_model.size();
			case (i % 3)
				0: send_request(make_req(plist_pkg::CMD_INS_BACK, extremes[i % 6], 8'd0));
				1: send_request(make_req(plist_pkg::CMD_INS_FRONT, extremes[i % 6], 8'd0));
				default: send_request(make_req(plist_pkg::CMD_INS_AT, extremes[i % 6],
					8'(size / 2 + 1)));
			endcase
		end
	endtask

	task automatic test_full_and_bad_positions();
		send_request(make_req(plist_pkg::CMD_INS_FRONT, 32'sd1, 8'd0));
		send_request(make_req(plist_pkg::CMD_INS_AT, 32'sd2, 8'(CAPACITY + 1)));
		send_request(make_req(plist_pkg::CMD_INS_AT, 32'sd3, 8'(CAPACITY + 2)));
		send_request(make_req(plist_pkg::CMD_DUMP, 32'sd0, 8'd0));
		send_request(make_req(plist_pkg::CMD_DEL_AT, 32'sd0, 8'd0));
		send_request(make_req(plist_pkg::CMD_DEL_AT, 32'sd0, 8'(CAPACITY + 1)));
		send_request(make_req(plist_pkg::CMD_DEL_AT, 32'sd0, 8'(CAPACITY)));
		send_request(make_req(plist_pkg::CMD_DEL_FRONT, 32'sd0, 8'd0));
		send_request(make_req(plist_pkg::CMD_DEL_BACK, 32'sd0, 8'd0));
		send_request(make_req(CMD_NOP, 32'sh7fffffff, 8'hff));
	endtask

	task automatic test_random_phase(input int sender_idle, input int receiver_stall,
			input int insert_pct, input int n_items);
		plist_pkg::req_t r;
		int roll;
		int size;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		for (int n = 0; n < n_items; n++) begin
			size = list_model.size();
			roll = $urandom_range(99);
			r.value = $urandom;
			r.position = 8'($urandom_range(255));
			if ($urandom_range(7) == 0)
				case ($urandom_range(3))
					0: r.value = 32'sh80000000;
					1: r.value = 32'sh7fffffff;
					2: r.value = 32'sh0;
					default: r.value = -32'sd1;
				endcase
			if (roll < insert_pct) begin
				case ($urandom_range(2))
					0: r.cmd = plist_pkg::CMD_INS_FRONT;
					1: r.cmd = plist_pkg::CMD_INS_BACK;
					default: r.cmd = plist_pkg::CMD_INS_AT;
				endcase
				if ($urandom_range(99) < 85)
					r.position = 8'($urandom_range(size + 1, 1));
			end else if (roll < 88) begin
				case ($urandom_range(2))
					0: r.cmd = plist_pkg::CMD_DEL_FRONT;
					1: r.cmd = plist_pkg::CMD_DEL_BACK;
					default: r.cmd = plist_pkg::CMD_DEL_AT;
				endcase
				if (size > 0 && $urandom_range(99) < 85)
					r.position = 8'($urandom_range(size, 1));
			end else if (roll < 97) begin
				r.cmd = plist_pkg::CMD_DUMP;
			end else begin
				r.cmd = CMD_NOP;
			end
			send_request(r);
		end
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_to_capacity();
		test_full_and_bad_positions();
		wait_drained();
		test_random_phase(0, 0, 65, 33);
		test_random_phase(74, 0, 40, 33);
		test_random_phase(0, 74, 60, 33);
		test_random_phase(35, 35, 45, 33);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests including %0d dumps, checked %0d responses.",
			n_requests, n_dumps, n_responses);
		$display("Statuses seen: ok %0d, bad position %0d, full %0d, empty %0d.",
			status_seen[plist_pkg::ST_OK], status_seen[plist_pkg::ST_BADPOS],
			status_seen[plist_pkg::ST_FULL], status_seen[plist_pkg::ST_EMPTY]);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/plist_pkg.sv
rtl/plist_cell.sv
rtl/positional_list_engine.sv
bench/tb_positional_list_engine.sv
